FILE: rtl/core/elro_pkg.sv
// Shared types, widths, constants and helper functions for the least-rotation
// ordering block. No dependencies; the top level imports it.
package elro_pkg;

  // Widths of the matrix entries and the pass-through eigenvalues.
  localparam int ENTRY_W = 16;
  localparam int EIG_W   = 32;

  // Widths of the determinant datapath and the candidate traces.
  localparam int PROD_W  = 2 * ENTRY_W;
  localparam int MINOR_W = PROD_W + 1;
  localparam int TERM_W  = MINOR_W + ENTRY_W;
  localparam int DET_W   = TERM_W + 2;
  localparam int TRACE_W = ENTRY_W + 2;

  // Candidate space: six column orders times four sign patterns.
  localparam int NUM_ORDERS = 6;
  localparam int NUM_SIGNS  = 4;
  localparam int ORD_W      = $clog2(NUM_ORDERS);
  localparam int SIGN_W     = $clog2(NUM_SIGNS);

  // Parity of each column order, bit p for order p (orders 021, 102, 210 are odd).
  localparam logic [NUM_ORDERS-1:0] ORDER_ODD = 6'b100110;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [EIG_W-1:0]   eig_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [MINOR_W-1:0] minor_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [DET_W-1:0]   det_t;
  typedef logic signed [TRACE_W-1:0] trace_t;
  typedef logic [ORD_W-1:0]          ord_t;
  typedef logic [SIGN_W-1:0]         sign_t;

  localparam entry_t ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};
  localparam entry_t ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};

  // Source column of candidate column k under column order p.
  function automatic logic [1:0] col_of(input ord_t p, input logic [1:0] k);
    logic [5:0] cols;
    unique case (p)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd1, 2'd2, 2'd0};
      3'd2:    cols = {2'd2, 2'd0, 2'd1};
      3'd3:    cols = {2'd0, 2'd2, 2'd1};
      3'd4:    cols = {2'd1, 2'd0, 2'd2};
      3'd5:    cols = {2'd0, 2'd1, 2'd2};
      default: cols = {2'd2, 2'd1, 2'd0};
    endcase
    return cols[2*k +: 2];
  endfunction

  // Negation that maps the most negative entry to the largest positive one.
  function automatic entry_t neg_sat(input entry_t x);
    return (x == ENTRY_MIN) ? ENTRY_MAX : -x;
  endfunction

  // Entry of a candidate, optionally negated.
  function automatic entry_t cand_entry(input entry_t x, input logic flip);
    return flip ? neg_sat(x) : x;
  endfunction

  // Whether the third column of candidate (p, s) is negated.
  function automatic logic cand_neg(input logic det_neg, input logic det_zero,
                                    input ord_t p, input sign_t s);
    return !det_zero && (det_neg ^ ORDER_ODD[p] ^ (s[1] ^ s[0]));
  endfunction

endpackage

FILE: rtl/core/eigenbasis_least_rotation_order_unit.sv
// Top level of the least-rotation ordering block: an eight-stage pipeline.
// Depends on elro_pkg for widths, types and the candidate helper functions.
//
// Usage:
//   One input word carries a 3x3 eigenvector matrix (vectors as columns,
//   Q1.14 entries) and the three eigenvalues of its columns. One output word
//   carries the candidate with the largest trace among 24 column orders and
//   sign patterns, third column fixed for a positive determinant, and the
//   eigenvalues in the same column order. Both channels are valid/ready.
// Path: an accepted word is registered in stage 0 and moves through each later
//   stage in turn up to the output register, where it waits for out_ready.
// Throughput: one word per cycle unless out_ready stalls. Each stage holds about
//   one rank of work: the 16x16 minor products, the minor subtracts, the 33x16
//   cofactor products, the determinant sum, the 24 traces, a best-of-four per
//   column order and a best-of-six with the output select.
// Stalls: every stage has its own valid bit and advances when it is empty or
//   the stage after it advances, so bubbles close up and new words are
//   taken while a finished word waits at the output register, until all stages are full.
// Reset: rst clears all valid bits; the pipeline is empty and in_ready is
//   high in the first cycle after reset.
module eigenbasis_least_rotation_order_unit
  import elro_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  entry_t vec_r0_c0,
  input  entry_t vec_r0_c1,
  input  entry_t vec_r0_c2,
  input  entry_t vec_r1_c0,
  input  entry_t vec_r1_c1,
  input  entry_t vec_r1_c2,
  input  entry_t vec_r2_c0,
  input  entry_t vec_r2_c1,
  input  entry_t vec_r2_c2,
  input  eig_t   eigval_0,
  input  eig_t   eigval_1,
  input  eig_t   eigval_2,
  output logic   out_valid,
  input  logic   out_ready,
  output entry_t out_r0_c0,
  output entry_t out_r0_c1,
  output entry_t out_r0_c2,
  output entry_t out_r1_c0,
  output entry_t out_r1_c1,
  output entry_t out_r1_c2,
  output entry_t out_r2_c0,
  output entry_t out_r2_c1,
  output entry_t out_r2_c2,
  output eig_t   out_eigval_0,
  output eig_t   out_eigval_1,
  output eig_t   out_eigval_2
);

  localparam int NUM_STAGES = 8;

  // Stage valid bits and per-stage advance enables.
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  entry_t in_mat [3][3];
  eig_t   in_eig [3];

  entry_t s0_mat [3][3];
  eig_t   s0_eig [3];
  entry_t s1_mat [3][3];
  eig_t   s1_eig [3];
  prod_t  s1_prod [6];
  entry_t s2_mat [3][3];
  eig_t   s2_eig [3];
  minor_t s2_minor [3];
  entry_t s3_mat [3][3];
  eig_t   s3_eig [3];
  term_t  s3_term [3];
  entry_t s4_mat [3][3];
  eig_t   s4_eig [3];
  logic   s4_neg;
  logic   s4_zero;
  entry_t s5_mat [3][3];
  eig_t   s5_eig [3];
  logic   s5_neg;
  logic   s5_zero;
  trace_t s5_trace [NUM_ORDERS][NUM_SIGNS];
  entry_t s6_mat [3][3];
  eig_t   s6_eig [3];
  logic   s6_neg;
  logic   s6_zero;
  sign_t  s6_sel [NUM_ORDERS];
  trace_t s6_best [NUM_ORDERS];
  entry_t o_mat [3][3];
  eig_t   o_eig [3];

  det_t   det;
  trace_t f_trace [NUM_ORDERS][NUM_SIGNS];
  sign_t  g_sel [NUM_ORDERS];
  trace_t g_best [NUM_ORDERS];
  trace_t pa_tr [NUM_ORDERS];
  sign_t  pa_s [NUM_ORDERS];
  trace_t pb_tr [NUM_ORDERS];
  sign_t  pb_s [NUM_ORDERS];
  ord_t   w01_p, w23_p, w45_p, w03_p, win_p;
  trace_t w01_tr, w23_tr, w45_tr, w03_tr, win_tr;
  sign_t  win_s;
  logic   win_neg;
  entry_t h_mat [3][3];
  eig_t   h_eig [3];

  // Input word as arrays.
  assign in_mat[0][0] = vec_r0_c0;
  assign in_mat[0][1] = vec_r0_c1;
  assign in_mat[0][2] = vec_r0_c2;
  assign in_mat[1][0] = vec_r1_c0;
  assign in_mat[1][1] = vec_r1_c1;
  assign in_mat[1][2] = vec_r1_c2;
  assign in_mat[2][0] = vec_r2_c0;
  assign in_mat[2][1] = vec_r2_c1;
  assign in_mat[2][2] = vec_r2_c2;
  assign in_eig[0]    = eigval_0;
  assign in_eig[1]    = eigval_1;
  assign in_eig[2]    = eigval_2;

  // A stage advances when it is empty or its successor advances.
  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NUM_STAGES-1];

  // Valid bits move along with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 0: input register.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_mat <= in_mat;
      s0_eig <= in_eig;
    end
  end

  // Stage 1: products of the lower two rows for the three cofactors.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_mat     <= s0_mat;
      s1_eig     <= s0_eig;
      s1_prod[0] <= s0_mat[1][1] * s0_mat[2][2];
      s1_prod[1] <= s0_mat[1][2] * s0_mat[2][1];
      s1_prod[2] <= s0_mat[1][0] * s0_mat[2][2];
      s1_prod[3] <= s0_mat[1][2] * s0_mat[2][0];
      s1_prod[4] <= s0_mat[1][0] * s0_mat[2][1];
      s1_prod[5] <= s0_mat[1][1] * s0_mat[2][0];
    end
  end

  // Stage 2: the three 2x2 minors.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_mat      <= s1_mat;
      s2_eig      <= s1_eig;
      s2_minor[0] <= minor_t'(s1_prod[0]) - minor_t'(s1_prod[1]);
      s2_minor[1] <= minor_t'(s1_prod[2]) - minor_t'(s1_prod[3]);
      s2_minor[2] <= minor_t'(s1_prod[4]) - minor_t'(s1_prod[5]);
    end
  end

  // Stage 3: minors times the top-row entries.
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_mat     <= s2_mat;
      s3_eig     <= s2_eig;
      s3_term[0] <= s2_minor[0] * s2_mat[0][0];
      s3_term[1] <= s2_minor[1] * s2_mat[0][1];
      s3_term[2] <= s2_minor[2] * s2_mat[0][2];
    end
  end

  // Stage 4: exact determinant, kept only as sign and zero flags.
  assign det = det_t'(s3_term[0]) - det_t'(s3_term[1]) + det_t'(s3_term[2]);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_mat  <= s3_mat;
      s4_eig  <= s3_eig;
      s4_neg  <= det[DET_W-1];
      s4_zero <= (det == '0);
    end
  end

  // Stage 5: traces of all 24 candidates from their saturated diagonals.
  always_comb begin
    for (int p = 0; p < NUM_ORDERS; p++) begin
      for (int s = 0; s < NUM_SIGNS; s++) begin
        f_trace[p][s] =
          trace_t'(cand_entry(s4_mat[0][col_of(ORD_W'(p), 2'd0)], s[1])) +
          trace_t'(cand_entry(s4_mat[1][col_of(ORD_W'(p), 2'd1)], s[0])) +
          trace_t'(cand_entry(s4_mat[2][col_of(ORD_W'(p), 2'd2)],
                              cand_neg(s4_neg, s4_zero, ORD_W'(p), SIGN_W'(s))));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_mat   <= s4_mat;
      s5_eig   <= s4_eig;
      s5_neg   <= s4_neg;
      s5_zero  <= s4_zero;
      s5_trace <= f_trace;
    end
  end

  // Stage 6: best sign pattern per column order; the earlier one wins a tie.
  always_comb begin
    for (int p = 0; p < NUM_ORDERS; p++) begin
      if (s5_trace[p][1] > s5_trace[p][0]) begin
        pa_tr[p] = s5_trace[p][1];
        pa_s[p]  = 2'd1;
      end else begin
        pa_tr[p] = s5_trace[p][0];
        pa_s[p]  = 2'd0;
      end
      if (s5_trace[p][3] > s5_trace[p][2]) begin
        pb_tr[p] = s5_trace[p][3];
        pb_s[p]  = 2'd3;
      end else begin
        pb_tr[p] = s5_trace[p][2];
        pb_s[p]  = 2'd2;
      end
      if (pb_tr[p] > pa_tr[p]) begin
        g_best[p] = pb_tr[p];
        g_sel[p]  = pb_s[p];
      end else begin
        g_best[p] = pa_tr[p];
        g_sel[p]  = pa_s[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_mat  <= s5_mat;
      s6_eig  <= s5_eig;
      s6_neg  <= s5_neg;
      s6_zero <= s5_zero;
      s6_sel  <= g_sel;
      s6_best <= g_best;
    end
  end

  // Stage 7: best column order by a left-preferring tree, then the output select.
  always_comb begin
    w01_p  = (s6_best[1] > s6_best[0]) ? 3'd1 : 3'd0;
    w01_tr = (s6_best[1] > s6_best[0]) ? s6_best[1] : s6_best[0];
    w23_p  = (s6_best[3] > s6_best[2]) ? 3'd3 : 3'd2;
    w23_tr = (s6_best[3] > s6_best[2]) ? s6_best[3] : s6_best[2];
    w45_p  = (s6_best[5] > s6_best[4]) ? 3'd5 : 3'd4;
    w45_tr = (s6_best[5] > s6_best[4]) ? s6_best[5] : s6_best[4];
    w03_p  = (w23_tr > w01_tr) ? w23_p : w01_p;
    w03_tr = (w23_tr > w01_tr) ? w23_tr : w01_tr;
    win_p  = (w45_tr > w03_tr) ? w45_p : w03_p;
    win_tr = (w45_tr > w03_tr) ? w45_tr : w03_tr;
    win_s   = s6_sel[win_p];
    win_neg = cand_neg(s6_neg, s6_zero, win_p, win_s);
    for (int r = 0; r < 3; r++) begin
      h_mat[r][0] = cand_entry(s6_mat[r][col_of(win_p, 2'd0)], win_s[1]);
      h_mat[r][1] = cand_entry(s6_mat[r][col_of(win_p, 2'd1)], win_s[0]);
      h_mat[r][2] = cand_entry(s6_mat[r][col_of(win_p, 2'd2)], win_neg);
    end
    for (int c = 0; c < 3; c++) begin
      h_eig[c] = s6_eig[col_of(win_p, 2'(c))];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      o_mat <= h_mat;
      o_eig <= h_eig;
    end
  end

  // Output word from the final register.
  assign out_r0_c0    = o_mat[0][0];
  assign out_r0_c1    = o_mat[0][1];
  assign out_r0_c2    = o_mat[0][2];
  assign out_r1_c0    = o_mat[1][0];
  assign out_r1_c1    = o_mat[1][1];
  assign out_r1_c2    = o_mat[1][2];
  assign out_r2_c0    = o_mat[2][0];
  assign out_r2_c1    = o_mat[2][1];
  assign out_r2_c2    = o_mat[2][2];
  assign out_eigval_0 = o_eig[0];
  assign out_eigval_1 = o_eig[1];
  assign out_eigval_2 = o_eig[2];

  // An accepted input word always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted word did not enter the first stage");

  // A stalled output word stays valid and keeps eigenvalues 0 and 2.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_eigval_0) &&
                                   $stable(out_eigval_2)))
    else $error("stalled output word changed");

  // The winning trace is no smaller than the best of any column order.
  a_win_max: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (win_tr >= s6_best[0] && win_tr >= s6_best[1] &&
                win_tr >= s6_best[2] && win_tr >= s6_best[3] &&
                win_tr >= s6_best[4] && win_tr >= s6_best[5]))
    else $error("selected candidate is not the largest trace");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

endmodule

FILE: bench/eigenbasis_least_rotation_order_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for eigenbasis_least_rotation_order_unit: directed and random words
// checked against a behavioral least-rotation picker. Depends on elro_pkg and the top level.
module eigenbasis_least_rotation_order_unit_test
  import elro_pkg::*;
();

  // One word on either channel: nine matrix entries (row-major) and three eigenvalues.
  typedef struct packed {
    eig_t   [2:0] ev;
    entry_t [8:0] m;
  } basis_word_t;

  localparam int RANDOM_WORDS        = 2000;
  localparam int BACKPRESSURE_AT     = 300;
  localparam int BACKPRESSURE_CYCLES = 400;
  localparam int IDLE_LIMIT          = 4000;
  localparam int DRAIN_CYCLES        = 20;

  localparam int EIG_LO = 32'sh8000_0000;
  localparam int EIG_HI = 32'sh7FFF_FFFF;
  localparam int EIG_A  = 32'sh5555_5555;
  localparam int EIG_B  = 32'shAAAA_AAAA;

  // Candidate column orders and their parity.
  localparam int COL_ORDER [6][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2},
                                      '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};
  localparam bit [5:0] ORDER_IS_ODD = 6'b100110;

  localparam int EDGE_VALUES [8] = '{-32768, -32767, -16384, -1, 0, 1, 16384, 32767};

  // Directed words: nine entries, then three eigenvalues. The first KNOWN_ROWS rows
  // carry a hand-written result; the rest are checked against the picker.
  localparam int DIRECTED_ROWS = 19;
  localparam int KNOWN_ROWS    = 4;
  localparam int DIRECTED_STIM [DIRECTED_ROWS][12] = '{
    '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384, EIG_LO, EIG_HI, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, EIG_HI, EIG_LO, -1},
    '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384, 1, 2, 3},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
      7, 8, 9},
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
      EIG_A, EIG_B, EIG_LO},
    '{0, 16384, 0, 0, 0, 16384, 16384, 0, 0, 10, 20, 30},
    '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384, 11, 21, 31},
    '{16384, 0, 0, 0, 16384, 0, 0, 0, -16384, EIG_B, EIG_A, EIG_HI},
    '{0, 16384, 0, 16384, 0, 0, 0, 0, 16384, -5, -6, -7},
    '{0, 0, 16384, 0, 16384, 0, 16384, 0, 0, 100, 200, 300},
    '{0, 0, -16384, -16384, 0, 0, 0, 16384, 0, 4, 5, 6},
    '{16384, 16384, 0, 0, 0, 16384, 16384, 16384, 0, 12, 13, 14},
    '{-32768, 32767, 0, 32767, -32768, 1, -1, 0, -32768, EIG_HI, 0, EIG_LO},
    '{11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384, 41, 42, 43},
    '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, 51, 52, 53},
    '{30000, -20000, 5, 123, -32768, 32767, -1, -1, -1, -100, 0, 100},
    '{0, 0, 0, 0, 0, 0, 0, 0, 1, 61, 62, 63},
    '{1, 0, 0, 0, -1, 0, 0, 0, 1, 71, 72, 73},
    '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384, EIG_A, EIG_A, EIG_B}
  };
  localparam int DIRECTED_WANT [KNOWN_ROWS][12] = '{
    '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384, EIG_LO, EIG_HI, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, EIG_HI, EIG_LO, -1},
    '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 1, 2, 3},
    '{32767, 32767, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 7, 8, 9}
  };

  // Clock and known values at time zero.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  basis_word_t in_word   = '0;
  basis_word_t out_word;

  entry_t vec_r0_c0, vec_r0_c1, vec_r0_c2, vec_r1_c0, vec_r1_c1, vec_r1_c2;
  entry_t vec_r2_c0, vec_r2_c1, vec_r2_c2;
  eig_t   eigval_0, eigval_1, eigval_2;
  entry_t out_r0_c0, out_r0_c1, out_r0_c2, out_r1_c0, out_r1_c1, out_r1_c2;
  entry_t out_r2_c0, out_r2_c1, out_r2_c2;
  eig_t   out_eigval_0, out_eigval_1, out_eigval_2;

  basis_word_t predicted_picks[$];
  int          mismatch_count = 0;
  int          results_seen   = 0;
  int          words_sent     = 0;
  int          idle_cycles    = 0;
  bit          send_calm      = 1'b0;

  assign {vec_r2_c2, vec_r2_c1, vec_r2_c0, vec_r1_c2, vec_r1_c1, vec_r1_c0,
          vec_r0_c2, vec_r0_c1, vec_r0_c0} = in_word.m;
  assign {eigval_2, eigval_1, eigval_0} = in_word.ev;
  assign out_word.m = {out_r2_c2, out_r2_c1, out_r2_c0, out_r1_c2, out_r1_c1, out_r1_c0,
                       out_r0_c2, out_r0_c1, out_r0_c0};
  assign out_word.ev = {out_eigval_2, out_eigval_1, out_eigval_0};

  eigenbasis_least_rotation_order_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vec_r0_c0    (vec_r0_c0),
    .vec_r0_c1    (vec_r0_c1),
    .vec_r0_c2    (vec_r0_c2),
    .vec_r1_c0    (vec_r1_c0),
    .vec_r1_c1    (vec_r1_c1),
    .vec_r1_c2    (vec_r1_c2),
    .vec_r2_c0    (vec_r2_c0),
    .vec_r2_c1    (vec_r2_c1),
    .vec_r2_c2    (vec_r2_c2),
    .eigval_0     (eigval_0),
    .eigval_1     (eigval_1),
    .eigval_2     (eigval_2),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_r0_c0    (out_r0_c0),
    .out_r0_c1    (out_r0_c1),
    .out_r0_c2    (out_r0_c2),
    .out_r1_c0    (out_r1_c0),
    .out_r1_c1    (out_r1_c1),
    .out_r1_c2    (out_r1_c2),
    .out_r2_c0    (out_r2_c0),
    .out_r2_c1    (out_r2_c1),
    .out_r2_c2    (out_r2_c2),
    .out_eigval_0 (out_eigval_0),
    .out_eigval_1 (out_eigval_1),
    .out_eigval_2 (out_eigval_2)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Negation that pins the most negative entry to the largest positive one.
  function automatic entry_t negate_clip(input entry_t x);
    return (x == ENTRY_MIN) ? ENTRY_MAX : entry_t'(-x);
  endfunction

  // Behavioral picker: the largest-trace candidate over six column orders and four
  // sign patterns, third column negated when the candidate's determinant is negative.
  function automatic basis_word_t least_rotation_pick(input basis_word_t w);
    entry_t      e [3][3];
    entry_t      cand [3][3];
    longint      m [3][3];
    longint      det;
    longint      tr;
    longint      best_tr;
    basis_word_t best;
    int          best_order;
    int          r;
    int          c;
    int          p;
    int          s;
    bit          det_neg;
    bit          det_zero;
    bit          flip0;
    bit          flip1;
    bit          flip2;
    best       = '0;
    best_order = 0;
    best_tr    = 0;
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++) begin
        e[r][c] = w.m[r*3 + c];
        m[r][c] = longint'(e[r][c]);
      end
    det = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
        - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
        + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    det_neg  = det < 0;
    det_zero = det == 0;
    for (p = 0; p < 6; p++) begin
      for (s = 0; s < 4; s++) begin
        flip0 = s[1];
        flip1 = s[0];
        flip2 = !det_zero && (det_neg ^ ORDER_IS_ODD[p] ^ flip0 ^ flip1);
        for (r = 0; r < 3; r++) begin
          cand[r][0] = flip0 ? negate_clip(e[r][COL_ORDER[p][0]]) : e[r][COL_ORDER[p][0]];
          cand[r][1] = flip1 ? negate_clip(e[r][COL_ORDER[p][1]]) : e[r][COL_ORDER[p][1]];
          cand[r][2] = flip2 ? negate_clip(e[r][COL_ORDER[p][2]]) : e[r][COL_ORDER[p][2]];
        end
        tr = longint'(cand[0][0]) + longint'(cand[1][1]) + longint'(cand[2][2]);
        // Strictly greater keeps the earliest candidate on a tie.
        if ((p == 0 && s == 0) || tr > best_tr) begin
          best_tr    = tr;
          best_order = p;
          for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
              best.m[r*3 + c] = cand[r][c];
        end
      end
    end
    for (c = 0; c < 3; c++)
      best.ev[c] = w.ev[COL_ORDER[best_order][c]];
    return best;
  endfunction

  // Random word: mostly scrambled rotations, plus signed permutations (many trace ties),
  // raw entries and entries drawn from the range extremes.
  function automatic basis_word_t draw_basis();
    basis_word_t w;
    real         q0;
    real         q1;
    real         q2;
    real         q3;
    real         n;
    real         v;
    real         rot [3][3];
    int          mode;
    int          perm;
    int          r;
    int          c;
    int          e;
    bit [2:0]    neg;
    bit          noisy;
    mode = $urandom_range(0, 99);
    for (c = 0; c < 3; c++)
      w.ev[c] = ($urandom_range(0, 9) == 0) ? eig_t'(($urandom_range(0, 1) == 1) ? EIG_HI : EIG_LO)
                                            : eig_t'($urandom());
    if (mode < 70) begin
      q0 = real'(int'($urandom_range(0, 2000)) - 1000);
      q1 = real'(int'($urandom_range(0, 2000)) - 1000);
      q2 = real'(int'($urandom_range(0, 2000)) - 1000);
      q3 = real'(int'($urandom_range(0, 2000)) - 1000);
      n  = $sqrt(q0*q0 + q1*q1 + q2*q2 + q3*q3);
      // Signed permutations come from the identity rotation.
      if (mode >= 55 || n < 1.0) begin
        q0 = 1.0; q1 = 0.0; q2 = 0.0; q3 = 0.0; n = 1.0;
      end
      q0 = q0 / n; q1 = q1 / n; q2 = q2 / n; q3 = q3 / n;
      rot[0][0] = 1.0 - 2.0 * (q2*q2 + q3*q3);
      rot[0][1] = 2.0 * (q1*q2 - q3*q0);
      rot[0][2] = 2.0 * (q1*q3 + q2*q0);
      rot[1][0] = 2.0 * (q1*q2 + q3*q0);
      rot[1][1] = 1.0 - 2.0 * (q1*q1 + q3*q3);
      rot[1][2] = 2.0 * (q2*q3 - q1*q0);
      rot[2][0] = 2.0 * (q1*q3 - q2*q0);
      rot[2][1] = 2.0 * (q2*q3 + q1*q0);
      rot[2][2] = 1.0 - 2.0 * (q1*q1 + q2*q2);
      perm  = $urandom_range(0, 5);
      neg   = 3'($urandom_range(0, 7));
      noisy = (mode < 55) && ($urandom_range(0, 3) == 0);
      for (r = 0; r < 3; r++)
        for (c = 0; c < 3; c++) begin
          v = rot[r][COL_ORDER[perm][c]] * 16384.0;
          if (neg[c]) v = -v;
          e = $rtoi(v + ((v < 0.0) ? -0.5 : 0.5));
          if (noisy) e = e + int'($urandom_range(0, 6)) - 3;
          w.m[r*3 + c] = entry_t'(e);
        end
    end else if (mode < 85) begin
      for (c = 0; c < 9; c++) w.m[c] = entry_t'($urandom());
    end else begin
      for (c = 0; c < 9; c++) w.m[c] = entry_t'(EDGE_VALUES[$urandom_range(0, 7)]);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  // Offer one word after a random gap, or none in a calm stretch, and hold it until accepted.
  task automatic send_word(input basis_word_t w, input bit known, input basis_word_t want);
    int          gap;
    basis_word_t pick;
    if (words_sent % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pick = known ? want : least_rotation_pick(w);
    predicted_picks = {predicted_picks, pick};
    words_sent++;
  endtask

  // Stimulus: reset, the directed table, then random words, then drain and verdict.
  initial begin : feed_words
    basis_word_t row_word;
    basis_word_t row_want;
    int          k;
    int          i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      row_want = '0;
      for (i = 0; i < 9; i++) row_word.m[i] = entry_t'(DIRECTED_STIM[k][i]);
      for (i = 0; i < 3; i++) row_word.ev[i] = eig_t'(DIRECTED_STIM[k][9 + i]);
      if (k < KNOWN_ROWS) begin
        for (i = 0; i < 9; i++) row_want.m[i] = entry_t'(DIRECTED_WANT[k][i]);
        for (i = 0; i < 3; i++) row_want.ev[i] = eig_t'(DIRECTED_WANT[k][9 + i]);
      end
      send_word(row_word, k < KNOWN_ROWS, row_want);
    end
    repeat (RANDOM_WORDS) send_word(draw_basis(), 1'b0, '0);
    in_valid <= 1'b0;
    while (predicted_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("eigenbasis_least_rotation_order_unit: match");
    else
      $display("eigenbasis_least_rotation_order_unit: mismatch");
    $finish;
  end

  // Result side: random stalls per word, calm stretches, and one long hold-off so the
  // pipeline fills and pushes back on the input.
  initial begin : drain_results
    int hold;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == BACKPRESSURE_AT) hold = BACKPRESSURE_CYCLES;
      else hold = calm ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Compare every accepted result with the oldest prediction, field by field.
  always @(posedge clk) begin : check_output
    basis_word_t want;
    int          i;
    if (!rst && out_valid && out_ready) begin
      if (predicted_picks.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing predicted", results_seen));
      end else begin
        want = predicted_picks.pop_front();
        for (i = 0; i < 9; i++)
          if (out_word.m[i] !== want.m[i])
            report_mismatch($sformatf("result %0d out_r%0d_c%0d: got %0d, expected %0d",
                            results_seen, i / 3, i % 3, $signed(out_word.m[i]),
                            $signed(want.m[i])));
        for (i = 0; i < 3; i++)
          if (out_word.ev[i] !== want.ev[i])
            report_mismatch($sformatf("result %0d out_eigval_%0d: got %0d, expected %0d",
                            results_seen, i, $signed(out_word.ev[i]),
                            $signed(want.ev[i])));
      end
      results_seen++;
    end
  end

  // Watchdog on cycles where neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("eigenbasis_least_rotation_order_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
rtl/core/elro_pkg.sv
rtl/core/eigenbasis_least_rotation_order_unit.sv
bench/eigenbasis_least_rotation_order_unit_test.sv
